/* hdl/base64_decoder_defines.svh */
// Assertion macros shared by the base64 decoder RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BASE64_DECODER_DEFINES_SVH
`define BASE64_DECODER_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define B64D_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define B64D_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/b64d_pkg.sv */
// Package for the base64 decoder: widths, character codes, phase type and
// the character map result struct. No dependencies.
`default_nettype none

package b64d_pkg;

    localparam int CHAR_W  = 8;
    localparam int SIXB_W  = 6;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3D;

    // Offsets added after subtracting the range base
    localparam logic [CHAR_W-1:0] LOWER_BASE = 8'd26;
    localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd52;
    localparam logic [SIXB_W-1:0] VAL_PLUS   = 6'd62;
    localparam logic [SIXB_W-1:0] VAL_SLASH  = 6'd63;

    // Position of a character within its group of four
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2,
        PH_3 = 2'd3
    } phase_t;

    typedef struct packed {
        logic              ok;
        logic [SIXB_W-1:0] value;
    } char_map_t;

endpackage : b64d_pkg

`default_nettype wire

/* hdl/b64d_if.sv */
// Valid/ready channel interfaces for the base64 decoder.
// Depends on b64d_pkg for field widths.
`default_nettype none

interface b64d_char_if
    import b64d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              final_char;

    modport source (output valid, output char_in, output final_char, input ready);
    modport sink   (input valid, input char_in, input final_char, output ready);
endinterface : b64d_char_if

interface b64d_byte_if
    import b64d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] data_byte;
    logic              last;
    logic              error;

    modport source (output valid, output data_byte, output last, output error, input ready);
    modport sink   (input valid, input data_byte, input last, input error, output ready);
endinterface : b64d_byte_if

`default_nettype wire

/* hdl/b64d_char_map.sv */
// Maps one base64 character to its 6-bit value and an alphabet flag.
// Depends on b64d_pkg.
`default_nettype none

module b64d_char_map
    import b64d_pkg::*;
(
    input  wire logic [CHAR_W-1:0] char_code,
    output char_map_t              map
);

    logic [CHAR_W-1:0] diff_upper;
    logic [CHAR_W-1:0] diff_lower;
    logic [CHAR_W-1:0] diff_digit;

    assign diff_upper = char_code - CH_UPPER_A;
    assign diff_lower = char_code - CH_LOWER_A + LOWER_BASE;
    assign diff_digit = char_code - CH_DIGIT_0 + DIGIT_BASE;

    always_comb
    begin
        map.ok    = 1'b1;
        map.value = '0;
        if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z)
        begin
            map.value = diff_upper[SIXB_W-1:0];
        end
        else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z)
        begin
            map.value = diff_lower[SIXB_W-1:0];
        end
        else if (char_code >= CH_DIGIT_0 && char_code <= CH_DIGIT_9)
        begin
            map.value = diff_digit[SIXB_W-1:0];
        end
        else if (char_code == CH_PLUS)
        begin
            map.value = VAL_PLUS;
        end
        else if (char_code == CH_SLASH)
        begin
            map.value = VAL_SLASH;
        end
        else if (char_code == CH_PAD)
        begin
            // pad decodes as zero and is accepted
            map.value = '0;
        end
        else
        begin
            map.ok = 1'b0;
        end
    end

endmodule : b64d_char_map

`default_nettype wire

/* hdl/base64_decoder.sv */
// Base64 decoder top level: one character item in, at most one byte item out.
// The character is held in the input register, and its byte in the result register.
// Throughput: 1 character per cycle while the result register is free or being drained; map and pack are combinational.
// Reset (rst_n low, asynchronous): both register stages empty, phase, held bits and
// sticky error cleared; the next character starts a new text.
// Depends on b64d_pkg, b64d_if.sv, b64d_char_map and base64_decoder_defines.svh.
`default_nettype none
`include "base64_decoder_defines.svh"

module base64_decoder
    import b64d_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    b64d_char_if.sink   chars,
    b64d_byte_if.source bytes
);

    // Input register stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_final_reg;

    // Decoder state
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [SIXB_W-1:0] held_reg;
    logic [SIXB_W-1:0] held_next;
    logic              bad_seen_reg;
    logic              bad_seen_next;

    // Result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] out_byte_reg;
    logic [CHAR_W-1:0] out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_error_reg;
    logic              out_error_next;

    char_map_t         cmap;
    logic              s1_go;
    logic              emit;
    logic              bad_now;
    logic [CHAR_W-1:0] pack_byte;

    b64d_char_map u_char_map (
        .char_code (s1_char_reg),
        .map       (cmap)
    );

    // Stage 1 moves on whenever the result register is free or being drained;
    // an item with no result moves on under the same condition to keep it simple.
    assign s1_go       = s1_valid_reg && (!out_valid_reg || bytes.ready);
    assign chars.ready = !s1_valid_reg || s1_go;

    assign bytes.valid     = out_valid_reg;
    assign bytes.data_byte = out_byte_reg;
    assign bytes.last      = out_last_reg;
    assign bytes.error     = out_error_reg;

    assign bad_now = bad_seen_reg || !cmap.ok;
    assign emit    = (phase_reg != PH_0) || s1_final_reg;

    // Big-endian packing of 6-bit groups into bytes
    always_comb
    begin
        case (phase_reg)
            PH_1:    pack_byte = {held_reg, cmap.value[5:4]};
            PH_2:    pack_byte = {held_reg[3:0], cmap.value[5:2]};
            PH_3:    pack_byte = {held_reg[1:0], cmap.value};
            default: pack_byte = '0;
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        phase_next     = phase_reg;
        held_next      = held_reg;
        bad_seen_next  = bad_seen_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_error_next = out_error_reg;

        // Drop the result once taken
        if (bytes.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (s1_go)
        begin
            s1_valid_next = 1'b0;
            if (s1_final_reg)
            begin
                // Close the text and start the next one clean
                phase_next    = PH_0;
                held_next     = '0;
                bad_seen_next = 1'b0;
            end
            else
            begin
                phase_next    = phase_t'(phase_reg + 2'd1);
                held_next     = cmap.value;
                bad_seen_next = bad_now;
            end

            if (emit)
            begin
                out_valid_next = 1'b1;
                out_last_next  = s1_final_reg;
                if (s1_final_reg && phase_reg == PH_0)
                begin
                    // Length is 1 mod 4: error-only final result
                    out_byte_next  = '0;
                    out_error_next = 1'b1;
                end
                else
                begin
                    out_byte_next  = pack_byte;
                    out_error_next = s1_final_reg && bad_now;
                end
            end
        end

        // Hold a new character in the input register
        if (chars.valid && chars.ready)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_0;
            held_reg      <= '0;
            bad_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            bad_seen_reg  <= bad_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s1_char_reg  <= chars.char_in;
            s1_final_reg <= chars.final_char;
        end
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_error_reg <= out_error_next;
    end

    `B64D_ASSERT_NOW(a_err_only_on_last, out_valid_reg && !out_last_reg, !out_error_reg,
        "error flagged on a result that is not last")
    `B64D_ASSERT_NEXT(a_state_clear_after_final, s1_go && s1_final_reg,
        phase_reg == PH_0 && !bad_seen_reg && held_reg == '0,
        "decoder state not cleared after final character")
    `B64D_ASSERT_NEXT(a_bad_length_result, s1_go && s1_final_reg && phase_reg == PH_0,
        out_valid_reg && out_last_reg && out_error_reg && out_byte_reg == '0,
        "bad length did not give an error-only final result")
    `B64D_ASSERT_NOW(a_stall_reason, !chars.ready,
        s1_valid_reg && out_valid_reg && !bytes.ready,
        "input stalled without a full pipeline")

endmodule : base64_decoder

`default_nettype wire

/* sim/base64_decoder_test.sv */
// Self-checking testbench for base64_decoder: drives character items, predicts decoded bytes.
// Depends on b64d_pkg, the channel interfaces in b64d_if.sv and the base64_decoder RTL.
`timescale 1ns / 100ps

module base64_decoder_test;
    import b64d_pkg::*;

    // Run length guard and receiver hold-off length, both in clock cycles
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 800;

    // One pending character with its pacing flags
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              fin;
        bit                drain_first;   // wait for all bytes out before offering
        bit                hold_rx;       // stall the receiver once this item is taken
    } char_item_t;

    // One decoded byte item as seen on the output channel
    typedef struct packed {
        logic [CHAR_W-1:0] data_byte;
        logic              last;
        logic              error;
    } byte_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    b64d_char_if char_ch ();
    b64d_byte_if byte_ch ();

    base64_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (char_ch),
        .bytes (byte_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Characters waiting to be offered, bytes waiting to come out
    char_item_t pending_chars[$];
    byte_item_t expected_bytes[$];

    // Decoder state mirrored by the predictor
    phase_t            dec_phase = PH_0;
    logic [SIXB_W-1:0] dec_held  = '0;
    logic              dec_bad   = 1'b0;

    // Handshake bookkeeping shared between the driver, monitor and receiver
    bit  offer_live    = 1'b0;
    bit  offer_hold    = 1'b0;
    bit  long_hold_req = 1'b0;
    int  tx_gap        = 0;
    int  rx_hold       = 0;
    int  rx_run        = 0;
    int  fail_cnt      = 0;
    int  cycle_cnt     = 0;

    // Flags that mark the next queued character
    bit  drain_req = 1'b0;
    bit  hold_req  = 1'b0;
    int  queued_cnt = 0;

    // Map one text character to its 6-bit value; ok is low outside the alphabet
    function automatic char_map_t char_to_sextet(input logic [CHAR_W-1:0] c);
        char_map_t         m;
        logic [CHAR_W-1:0] off;
        m.ok  = 1'b1;
        off   = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            off = c - CH_UPPER_A;
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            off = c - CH_LOWER_A + LOWER_BASE;
        else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            off = c - CH_DIGIT_0 + DIGIT_BASE;
        else if (c == CH_PLUS)
            off = {2'b00, VAL_PLUS};
        else if (c == CH_SLASH)
            off = {2'b00, VAL_SLASH};
        else if (c != CH_PAD)
            m.ok = 1'b0;
        // the pad character decodes as zero, so off stays zero for it
        m.value = off[SIXB_W-1:0];
        return m;
    endfunction

    // Advance the mirrored decoder by one accepted character, queue any byte it yields
    task automatic decode_char_item(input logic [CHAR_W-1:0] ch, input logic fin);
        char_map_t         m;
        logic [CHAR_W-1:0] b;
        bit                emit;
        byte_item_t        res;
        m    = char_to_sextet(ch);
        emit = 1'b1;
        b    = '0;
        // an invalid character counts as zero but poisons the whole text
        if (!m.ok)
            dec_bad = 1'b1;
        case (dec_phase)
            PH_0:    emit = 1'b0;
            PH_1:    b = {dec_held, m.value[5:4]};
            PH_2:    b = {dec_held[3:0], m.value[5:2]};
            default: b = {dec_held[1:0], m.value};
        endcase
        dec_held  = m.value;
        dec_phase = phase_t'(dec_phase + 2'd1);
        if (fin)
        begin
            // a final character at phase zero means length 1 mod 4: error-only byte
            res.data_byte = emit ? b : '0;
            res.last      = 1'b1;
            res.error     = emit ? dec_bad : 1'b1;
            expected_bytes.push_back(res);
            dec_phase = PH_0;
            dec_held  = '0;
            dec_bad   = 1'b0;
        end
        else if (emit)
        begin
            res.data_byte = b;
            res.last      = 1'b0;
            res.error     = 1'b0;
            expected_bytes.push_back(res);
        end
    endtask

    // Queue one character, attaching any pending pacing request
    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic fin);
        char_item_t it;
        it.ch          = ch;
        it.fin         = fin;
        it.drain_first = drain_req;
        it.hold_rx     = hold_req;
        drain_req      = 1'b0;
        hold_req       = 1'b0;
        pending_chars.push_back(it);
        queued_cnt++;
    endtask

    // Queue a whole text from a string, final flag on its last character
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [CHAR_W-1:0] pick_alphabet_char();
        int r;
        r = $urandom_range(0, 64);
        if (r < 26)
            return CHAR_W'(CH_UPPER_A + r);
        else if (r < 52)
            return CHAR_W'(CH_LOWER_A + (r - 26));
        else if (r < 62)
            return CHAR_W'(CH_DIGIT_0 + (r - 52));
        else if (r == 62)
            return CH_PLUS;
        else if (r == 63)
            return CH_SLASH;
        return CH_PAD;
    endfunction

    // Half the time a neighbor of an alphabet range, else any byte outside the alphabet
    function automatic logic [CHAR_W-1:0] pick_bad_char();
        logic [CHAR_W-1:0] near_miss[10];
        logic [CHAR_W-1:0] c;
        char_map_t         m;
        near_miss = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h3A, 8'h2A, 8'h2C, 8'h2E, 8'h3C, 8'h3E};
        if ($urandom_range(0, 1) == 0)
            return near_miss[$urandom_range(0, 9)];
        c = CHAR_W'($urandom_range(0, 255));
        m = char_to_sextet(c);
        while (m.ok)
        begin
            c = CHAR_W'($urandom_range(0, 255));
            m = char_to_sextet(c);
        end
        return c;
    endfunction

    // One random text: mostly clean with a sane length, some with bad characters, some noise
    task automatic push_random_text();
        int                len;
        int                bad_pct;
        int                r;
        logic [CHAR_W-1:0] c;
        r   = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        if (r < 75)
        begin
            bad_pct = 0;
            if (len % 4 == 1)
                len++;
        end
        else if (r < 90)
            bad_pct = $urandom_range(5, 40);
        else
            bad_pct = 100;
        for (int i = 0; i < len; i++)
        begin
            if (bad_pct == 100)
                c = CHAR_W'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) < bad_pct)
                c = pick_bad_char();
            else
                c = pick_alphabet_char();
            push_char(c, i == len - 1);
        end
    endtask

    // Sender gap after an item: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: change inputs on the falling edge, hold an offer until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            char_ch.valid <= 1'b0;
        else if (offer_live)
        begin
            // hold the current item until the handshake completes
        end
        else if (tx_gap > 0)
        begin
            tx_gap--;
            char_ch.valid <= 1'b0;
        end
        else if (pending_chars.size() != 0 &&
                 (!pending_chars[0].drain_first || expected_bytes.size() == 0))
        begin
            char_ch.valid      <= 1'b1;
            char_ch.char_in    <= pending_chars[0].ch;
            char_ch.final_char <= pending_chars[0].fin;
            offer_hold          = pending_chars[0].hold_rx;
            offer_live          = 1'b1;
            void'(pending_chars.pop_front());
            tx_gap = pick_gap();
        end
        else
            char_ch.valid <= 1'b0;
    end

    // Input side: sample the handshake on the rising edge and advance the prediction
    always @(posedge clk)
    begin
        if (rst_n && char_ch.valid && char_ch.ready)
        begin
            decode_char_item(char_ch.char_in, char_ch.final_char);
            offer_live = 1'b0;
            if (offer_hold)
                long_hold_req = 1'b1;
        end
    end

    // Receiver: random ready runs and stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            byte_ch.ready <= 1'b0;
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            rx_hold       = LONG_HOLD;
            rx_run        = 0;
            byte_ch.ready <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold--;
            byte_ch.ready <= 1'b0;
        end
        else if (rx_run > 0)
        begin
            rx_run--;
            byte_ch.ready <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 70)
        begin
            rx_run = $urandom_range(0, 30);
            byte_ch.ready <= 1'b1;
        end
        else
        begin
            rx_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(0, 2);
            byte_ch.ready <= 1'b0;
        end
    end

    // Monitor: compare each accepted byte item with the oldest expectation
    always @(posedge clk)
    begin
        byte_item_t got;
        byte_item_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            got.data_byte = byte_ch.data_byte;
            got.last      = byte_ch.last;
            got.error     = byte_ch.error;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected item data_byte=%h last=%b error=%b",
                         $time, got.data_byte, got.last, got.error);
                fail_cnt++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (got.data_byte !== want.data_byte || got.last !== want.last ||
                    got.error !== want.error)
                begin
                    $display("%0t: mismatch expected %h/%b/%b, got %h/%b/%b",
                             $time, want.data_byte, want.last, want.error,
                             got.data_byte, got.last, got.error);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d items still expected", $time, expected_bytes.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        char_ch.valid      = 1'b0;
        char_ch.char_in    = '0;
        char_ch.final_char = 1'b0;
        byte_ch.ready      = 1'b0;

        // Directed texts: a lone character (length 1 mod 4), all-ones bytes,
        // pad characters, an invalid character mid-group, the extreme bytes
        // 0x00 and 0xFF as invalid input, and final characters at phases 1 and 2.
        push_text("A");
        push_text("////");
        push_text("QQ==");
        push_text("Z*9+");
        push_char(8'hFF, 1'b0);
        push_char(CH_LOWER_A, 1'b0);
        push_char(8'h00, 1'b0);
        push_char(CH_LOWER_Z, 1'b1);
        push_text("az");
        push_text("09+");

        // Random texts; let the directed part drain before they start, stall the
        // receiver for a long stretch part way in, and drain again later on.
        drain_req = 1'b1;
        while (queued_cnt < RANDOM_ITEMS)
        begin
            if (queued_cnt >= 300 && queued_cnt < 320)
                hold_req = 1'b1;
            if (queued_cnt >= 550 && queued_cnt < 570)
                drain_req = 1'b1;
            push_random_text();
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every character is taken and every byte has come out
        while (pending_chars.size() != 0 || offer_live)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        // catch any stray item the block still puts out
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule : base64_decoder_test
